// ===== rtl/core/arsg_pkg.sv =====
// Shared constants, types and tables for the axial rotary sin/cos generator.
package arsg_pkg;

    localparam int EMB_DIM_DEF       = 64;
    localparam int CORDIC_STAGES_DEF = 16;

    localparam int POS_W       = 7;
    localparam int SCALE_W     = 17;
    localparam int IDX_W       = 5;
    localparam int OUT_W       = 16;
    localparam int K_W         = 4;
    localparam int ROM_W       = 25;
    localparam int ATAN_W      = 30;
    localparam int PROD_W      = POS_W + SCALE_W;
    localparam int ANGLE_W     = PROD_W + ROM_W;
    localparam int ANGLE_SHIFT = 10;
    localparam int REM_W       = ANGLE_W - ANGLE_SHIFT;
    localparam int MOD_STEPS   = 6;
    localparam int Z_W         = 34;
    localparam int XY_W        = 34;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [SCALE_W-1:0]   SCALE_RESET  = 17'd65536;
    localparam logic [32:0]          TWO_PI_Q30   = 33'd6746518852;
    localparam logic signed [Z_W-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic [63:0]          GAIN_Q30     = 64'd652032874;
    localparam logic [63:0]          GAIN_FIX_Q30 = 64'd434688582;
    localparam int                   OUT_ONE      = 16384;
    localparam int                   ROUND_HALF   = 32768;
    localparam int                   ROUND_SHIFT  = 16;

    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] column;
    } t_pos;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             last;
    } t_meta;

    typedef struct packed {
        t_meta            meta;
        logic [POS_W-1:0] pos;
        logic [K_W-1:0]   k;
    } t_cmd;

    // 10^(-k/4) in Q1.24
    function automatic logic [ROM_W-1:0] freq_rom(input logic [K_W-1:0] k);
        logic [ROM_W-1:0] v;
        case (k)
            4'd0:    v = 25'd16777216;
            4'd1:    v = 25'd9434522;
            4'd2:    v = 25'd5305422;
            4'd3:    v = 25'd2983458;
            4'd4:    v = 25'd1677722;
            4'd5:    v = 25'd943452;
            4'd6:    v = 25'd530542;
            4'd7:    v = 25'd298346;
            4'd8:    v = 25'd167772;
            4'd9:    v = 25'd94345;
            4'd10:   v = 25'd53054;
            4'd11:   v = 25'd29835;
            4'd12:   v = 25'd16777;
            4'd13:   v = 25'd9435;
            4'd14:   v = 25'd5305;
            4'd15:   v = 25'd2983;
            default: v = '0;
        endcase
        return v;
    endfunction

    // atan(2^-i) in Q30
    function automatic logic [ATAN_W-1:0] atan_q30(input int i);
        logic [ATAN_W-1:0] v;
        case (i)
            0:       v = 30'd843314856;
            1:       v = 30'd497837829;
            2:       v = 30'd263043836;
            3:       v = 30'd133525158;
            4:       v = 30'd67021686;
            5:       v = 30'd33543515;
            6:       v = 30'd16775850;
            7:       v = 30'd8388437;
            8:       v = 30'd4194282;
            9:       v = 30'd2097149;
            10:      v = 30'd1048575;
            11:      v = 30'd524287;
            12:      v = 30'd262143;
            13:      v = 30'd131071;
            14:      v = 30'd65535;
            15:      v = 30'd32767;
            16:      v = 30'd16383;
            17:      v = 30'd8191;
            18:      v = 30'd4095;
            19:      v = 30'd2047;
            20:      v = 30'd1023;
            21:      v = 30'd511;
            22:      v = 30'd255;
            23:      v = 30'd127;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/arsg_front.sv =====
// Front end: position queue and per-slot command sequencer.
module arsg_front #(
    parameter int EMB_DIM = arsg_pkg::EMB_DIM_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [arsg_pkg::POS_W-1:0] i_row,
    input  logic [arsg_pkg::POS_W-1:0] i_column,
    input  logic                      i_adv,
    output logic                      o_cmd_valid,
    output arsg_pkg::t_cmd            o_cmd
);
    import arsg_pkg::*;

    localparam int PER_AXIS = EMB_DIM / 4;
    localparam int TOTAL    = 2 * PER_AXIS;
    localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);

    t_pos             r_queue [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic [IDX_W-1:0]  r_slot;

    logic             push;
    logic             pop;
    logic             head_valid;
    logic             slot_last;
    logic             first_axis;
    logic [K_W-1:0]   axis_slot;
    logic [K_W-1:0]   slot_k;
    t_pos             head;

    assign head       = r_queue[r_rd_ptr];
    assign head_valid = (r_count != '0);
    assign o_ready    = (r_count != CNT_W'(QUEUE_DEPTH));
    assign push       = i_valid && o_ready;
    assign slot_last  = (r_slot == IDX_W'(TOTAL - 1));
    assign pop        = i_adv && head_valid && slot_last;
    assign first_axis = (r_slot < IDX_W'(PER_AXIS));

    always_comb begin
        if (first_axis) begin
            axis_slot = r_slot[K_W-1:0];
        end else begin
            axis_slot = K_W'(r_slot - IDX_W'(PER_AXIS));
        end
        // ROM index per slot, rounded down; a constant table
        slot_k = '0;
        for (int s = 0; s < PER_AXIS; s++) begin
            if (axis_slot == K_W'(s)) begin
                slot_k = K_W'((64 * s) / EMB_DIM);
            end
        end
        o_cmd_valid    = head_valid;
        o_cmd.meta.idx  = r_slot;
        o_cmd.meta.last = slot_last;
        o_cmd.pos      = first_axis ? head.column : head.row;
        o_cmd.k        = slot_k;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= '{row: i_row, column: i_column};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_slot   <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
            if (i_adv && head_valid) begin
                r_slot <= slot_last ? '0 : r_slot + 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/arsg_angle.sv =====
// Back end, first half: angle products, modulo 2*pi and quadrant fold.
module arsg_angle (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_adv,
    input  logic                              i_valid,
    input  arsg_pkg::t_cmd                    i_cmd,
    input  logic [arsg_pkg::SCALE_W-1:0]      i_scale,
    output logic                              o_valid,
    output arsg_pkg::t_meta                   o_meta,
    output logic signed [arsg_pkg::Z_W-1:0]   o_z,
    output logic                              o_neg
);
    import arsg_pkg::*;

    logic              r_s1_valid;
    t_meta             r_s1_meta;
    logic [K_W-1:0]    r_s1_k;
    logic [PROD_W-1:0] r_s1_prod;

    logic [ANGLE_W-1:0] s2_prod;

    logic [REM_W-1:0] r_md_rem   [MOD_STEPS+1];
    t_meta            r_md_meta  [MOD_STEPS+1];
    logic             r_md_valid [MOD_STEPS+1];
    logic [REM_W:0]   md_diff    [MOD_STEPS];
    logic [REM_W-1:0] md_next    [MOD_STEPS];

    logic signed [Z_W-1:0] f1_in;
    logic signed [Z_W-1:0] f1_z;
    logic                  r_f1_valid;
    t_meta                 r_f1_meta;
    logic signed [Z_W-1:0] r_f1_z;

    logic signed [Z_W-1:0] f2_z;
    logic                  f2_neg;
    logic                  r_f2_valid;
    t_meta                 r_f2_meta;
    logic signed [Z_W-1:0] r_f2_z;
    logic                  r_f2_neg;

    assign s2_prod = {{ROM_W{1'b0}}, r_s1_prod} * {{PROD_W{1'b0}}, freq_rom(r_s1_k)};

    // restoring reduction by 2*pi*2^m, one multiple per stage
    always_comb begin
        for (int j = 0; j < MOD_STEPS; j++) begin
            md_diff[j] = {1'b0, r_md_rem[j]}
                       - ({1'b0, REM_W'(TWO_PI_Q30)} << (MOD_STEPS - 1 - j));
            md_next[j] = md_diff[j][REM_W] ? r_md_rem[j] : md_diff[j][REM_W-1:0];
        end
    end

    always_comb begin
        f1_in = $signed({1'b0, r_md_rem[MOD_STEPS][Z_W-2:0]});
        f1_z  = f1_in;
        if (f1_in > PI_Q30) begin
            f1_z = f1_in - $signed(Z_W'(TWO_PI_Q30));
        end
    end

    always_comb begin
        f2_z   = r_f1_z;
        f2_neg = 1'b0;
        if (r_f1_z > HALF_PI_Q30) begin
            f2_z   = r_f1_z - PI_Q30;
            f2_neg = 1'b1;
        end else if (r_f1_z < -HALF_PI_Q30) begin
            f2_z   = r_f1_z + PI_Q30;
            f2_neg = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s1_meta    <= i_cmd.meta;
            r_s1_k       <= i_cmd.k;
            r_s1_prod    <= PROD_W'(i_cmd.pos) * PROD_W'(i_scale);
            r_md_rem[0]  <= s2_prod[ANGLE_W-1:ANGLE_SHIFT];
            r_md_meta[0] <= r_s1_meta;
            for (int j = 0; j < MOD_STEPS; j++) begin
                r_md_rem[j+1]  <= md_next[j];
                r_md_meta[j+1] <= r_md_meta[j];
            end
            r_f1_meta <= r_md_meta[MOD_STEPS];
            r_f1_z    <= f1_z;
            r_f2_meta <= r_f1_meta;
            r_f2_z    <= f2_z;
            r_f2_neg  <= f2_neg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            for (int j = 0; j <= MOD_STEPS; j++) begin
                r_md_valid[j] <= 1'b0;
            end
            r_f1_valid <= 1'b0;
            r_f2_valid <= 1'b0;
        end else if (i_adv) begin
            r_s1_valid    <= i_valid;
            r_md_valid[0] <= r_s1_valid;
            for (int j = 0; j < MOD_STEPS; j++) begin
                r_md_valid[j+1] <= r_md_valid[j];
            end
            r_f1_valid <= r_md_valid[MOD_STEPS];
            r_f2_valid <= r_f1_valid;
        end
    end

    assign o_valid = r_f2_valid;
    assign o_meta  = r_f2_meta;
    assign o_z     = r_f2_z;
    assign o_neg   = r_f2_neg;

endmodule

// ===== rtl/core/arsg_cordic.sv =====
// Back end, second half: pipelined CORDIC rotation, sign fix and Q2.14 rounding.
module arsg_cordic #(
    parameter int CORDIC_STAGES = arsg_pkg::CORDIC_STAGES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_adv,
    input  logic                              i_valid,
    input  arsg_pkg::t_meta                   i_meta,
    input  logic signed [arsg_pkg::Z_W-1:0]   i_z,
    input  logic                              i_neg,
    output logic                              o_valid,
    output logic [arsg_pkg::IDX_W-1:0]        o_entry_index,
    output logic signed [arsg_pkg::OUT_W-1:0] o_cosine,
    output logic signed [arsg_pkg::OUT_W-1:0] o_sine,
    output logic                              o_last_entry
);
    import arsg_pkg::*;

    localparam logic [63:0] X0_WIDE = GAIN_Q30 + (GAIN_FIX_Q30 >> (2 * CORDIC_STAGES));
    localparam logic signed [XY_W-1:0] X0 = $signed(X0_WIDE[XY_W-1:0]);
    localparam int Q_W = XY_W + 1 - ROUND_SHIFT;
    localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(OUT_ONE);
    localparam logic signed [Q_W-1:0] Q_MIN = -Q_MAX;

    logic signed [XY_W-1:0] r_x    [CORDIC_STAGES];
    logic signed [XY_W-1:0] r_y    [CORDIC_STAGES];
    logic signed [Z_W-1:0]  r_z    [CORDIC_STAGES];
    logic                   r_neg  [CORDIC_STAGES];
    t_meta                  r_meta [CORDIC_STAGES];
    logic                   r_vld  [CORDIC_STAGES];

    logic signed [XY_W-1:0] sx  [CORDIC_STAGES];
    logic signed [XY_W-1:0] sy  [CORDIC_STAGES];
    logic signed [Z_W-1:0]  sz  [CORDIC_STAGES];
    logic signed [XY_W-1:0] n_x [CORDIC_STAGES];
    logic signed [XY_W-1:0] n_y [CORDIC_STAGES];
    logic signed [Z_W-1:0]  n_z [CORDIC_STAGES];

    logic                   r_sg_valid;
    t_meta                  r_sg_meta;
    logic signed [XY_W-1:0] r_sg_x;
    logic signed [XY_W-1:0] r_sg_y;

    logic signed [XY_W:0]   cos_sum;
    logic signed [XY_W:0]   sin_sum;
    logic signed [Q_W-1:0]  cos_q;
    logic signed [Q_W-1:0]  sin_q;

    logic                   r_out_valid;
    t_meta                  r_out_meta;
    logic signed [OUT_W-1:0] r_cos;
    logic signed [OUT_W-1:0] r_sin;

    function automatic logic signed [OUT_W-1:0] clamp_q(input logic signed [Q_W-1:0] v);
        logic signed [OUT_W-1:0] r;
        if (v > Q_MAX) begin
            r = OUT_W'(Q_MAX);
        end else if (v < Q_MIN) begin
            r = OUT_W'(Q_MIN);
        end else begin
            r = OUT_W'(v);
        end
        return r;
    endfunction

    always_comb begin
        sx[0] = X0;
        sy[0] = '0;
        sz[0] = i_z;
        for (int i = 1; i < CORDIC_STAGES; i++) begin
            sx[i] = r_x[i-1];
            sy[i] = r_y[i-1];
            sz[i] = r_z[i-1];
        end
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            if (!sz[i][Z_W-1]) begin
                n_x[i] = sx[i] - (sy[i] >>> i);
                n_y[i] = sy[i] + (sx[i] >>> i);
                n_z[i] = sz[i] - $signed(Z_W'(atan_q30(i)));
            end else begin
                n_x[i] = sx[i] + (sy[i] >>> i);
                n_y[i] = sy[i] - (sx[i] >>> i);
                n_z[i] = sz[i] + $signed(Z_W'(atan_q30(i)));
            end
        end
    end

    always_comb begin
        cos_sum = $signed({r_sg_x[XY_W-1], r_sg_x}) + $signed((XY_W + 1)'(ROUND_HALF));
        sin_sum = $signed({r_sg_y[XY_W-1], r_sg_y}) + $signed((XY_W + 1)'(ROUND_HALF));
        cos_q   = cos_sum[XY_W:ROUND_SHIFT];
        sin_q   = sin_sum[XY_W:ROUND_SHIFT];
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int i = 0; i < CORDIC_STAGES; i++) begin
                r_x[i] <= n_x[i];
                r_y[i] <= n_y[i];
                r_z[i] <= n_z[i];
            end
            r_neg[0]  <= i_neg;
            r_meta[0] <= i_meta;
            for (int i = 1; i < CORDIC_STAGES; i++) begin
                r_neg[i]  <= r_neg[i-1];
                r_meta[i] <= r_meta[i-1];
            end
            r_sg_meta  <= r_meta[CORDIC_STAGES-1];
            r_sg_x     <= r_neg[CORDIC_STAGES-1] ? -r_x[CORDIC_STAGES-1] : r_x[CORDIC_STAGES-1];
            r_sg_y     <= r_neg[CORDIC_STAGES-1] ? -r_y[CORDIC_STAGES-1] : r_y[CORDIC_STAGES-1];
            r_out_meta <= r_sg_meta;
            r_cos      <= clamp_q(cos_q);
            r_sin      <= clamp_q(sin_q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CORDIC_STAGES; i++) begin
                r_vld[i] <= 1'b0;
            end
            r_sg_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (i_adv) begin
            r_vld[0] <= i_valid;
            for (int i = 1; i < CORDIC_STAGES; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
            r_sg_valid  <= r_vld[CORDIC_STAGES-1];
            r_out_valid <= r_sg_valid;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_entry_index = r_out_meta.idx;
    assign o_last_entry  = r_out_meta.last;
    assign o_cosine      = r_cos;
    assign o_sine        = r_sin;

endmodule

// ===== rtl/core/axial_rope_sincos_generator_top.sv =====
// Top level of the axial rotary position embedding sin/cos generator.
//
//   channel   direction  handshake              payload
//   input     in         i_valid / o_ready      i_row, i_column
//   result    out        o_valid / i_ready      o_entry_index, o_cosine, o_sine, o_last_entry
//   config    in         i_cfg_wr_en            i_cfg_wr_data (angle_scale)
//
// One result per cycle while results are accepted; a position is expanded into 2*(EMB_DIM/4)
// slots (32 by default) by the slot sequencer, which issues one slot per cycle into the shared
// CORDIC pipeline unless a held result stalls it.
// Reset is synchronous; angle_scale returns to 1.0 and all pipeline valids clear.
// A held result freezes the whole back end; the four-entry position queue keeps
// taking items until it fills.
module axial_rope_sincos_generator_top #(
    parameter int EMB_DIM       = arsg_pkg::EMB_DIM_DEF,
    parameter int CORDIC_STAGES = arsg_pkg::CORDIC_STAGES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [arsg_pkg::POS_W-1:0]        i_row,
    input  logic [arsg_pkg::POS_W-1:0]        i_column,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [arsg_pkg::IDX_W-1:0]        o_entry_index,
    output logic signed [arsg_pkg::OUT_W-1:0] o_cosine,
    output logic signed [arsg_pkg::OUT_W-1:0] o_sine,
    output logic                              o_last_entry,
    input  logic                              i_cfg_wr_en,
    input  logic [arsg_pkg::SCALE_W-1:0]      i_cfg_wr_data
);
    import arsg_pkg::*;

    logic [SCALE_W-1:0]    r_angle_scale;
    logic                  adv;
    logic                  cmd_valid;
    t_cmd                  cmd;
    logic                  ang_valid;
    t_meta                 ang_meta;
    logic signed [Z_W-1:0] ang_z;
    logic                  ang_neg;

    assign adv = !o_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle_scale <= SCALE_RESET;
        end else if (i_cfg_wr_en) begin
            r_angle_scale <= i_cfg_wr_data;
        end
    end

    arsg_front #(
        .EMB_DIM(EMB_DIM)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_row      (i_row),
        .i_column   (i_column),
        .i_adv      (adv),
        .o_cmd_valid(cmd_valid),
        .o_cmd      (cmd)
    );

    arsg_angle u_angle (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_adv  (adv),
        .i_valid(cmd_valid),
        .i_cmd  (cmd),
        .i_scale(r_angle_scale),
        .o_valid(ang_valid),
        .o_meta (ang_meta),
        .o_z    (ang_z),
        .o_neg  (ang_neg)
    );

    arsg_cordic #(
        .CORDIC_STAGES(CORDIC_STAGES)
    ) u_cordic (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (adv),
        .i_valid      (ang_valid),
        .i_meta       (ang_meta),
        .i_z          (ang_z),
        .i_neg        (ang_neg),
        .o_valid      (o_valid),
        .o_entry_index(o_entry_index),
        .o_cosine     (o_cosine),
        .o_sine       (o_sine),
        .o_last_entry (o_last_entry)
    );

endmodule

// ===== rtl/core/arsg_checker.sv =====
// Port-level assertions for the sin/cos generator, bound to the top level.
module arsg_checker #(
    parameter int EMB_DIM = arsg_pkg::EMB_DIM_DEF
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_valid,
    input logic                              i_ready,
    input logic [arsg_pkg::IDX_W-1:0]        o_entry_index,
    input logic signed [arsg_pkg::OUT_W-1:0] o_cosine,
    input logic signed [arsg_pkg::OUT_W-1:0] o_sine,
    input logic                              o_last_entry
);
    import arsg_pkg::*;

    localparam int TOTAL = 2 * (EMB_DIM / 4);
    localparam logic signed [OUT_W-1:0] LIM = OUT_W'(OUT_ONE);

    logic [IDX_W-1:0] r_exp_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_idx <= '0;
        end else if (o_valid && i_ready) begin
            r_exp_idx <= o_last_entry ? '0 : o_entry_index + 1'b1;
        end
    end

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_entry_index) && $stable(o_cosine)
            && $stable(o_sine) && $stable(o_last_entry))
        else $error("stalled result changed");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready |-> o_entry_index == r_exp_idx)
        else $error("slot out of order");

    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_last_entry == (o_entry_index == IDX_W'(TOTAL - 1)))
        else $error("last flag on wrong slot");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_cosine <= LIM && o_cosine >= -LIM && o_sine <= LIM && o_sine >= -LIM)
        else $error("output beyond unit range");

endmodule

bind axial_rope_sincos_generator_top arsg_checker #(.EMB_DIM(EMB_DIM)) u_arsg_checker (.*);
